// File: sv/qte_pkg.sv
// Shared types, widths and the arctangent table for the quaternion to Euler block.
package qte_pkg;

  localparam int DEF_CORDIC_STEPS = 16;
  localparam int ATAN_LEN         = 24;

  localparam int QW   = 16;   // quaternion component width, Q1.14
  localparam int AW   = 16;   // binary angle width
  localparam int PW   = 32;   // 16x16 product width
  localparam int TW   = 34;   // Q28 product term width
  localparam int CW   = 37;   // CORDIC x/y width, leaves headroom for gain
  localparam int ZW   = 34;   // CORDIC angle accumulator, pi = 2^31
  localparam int MW   = 28;   // |s| width when pitch is not clamped
  localparam int RW   = 58;   // square root remainder and root width
  localparam int SQRT_BITS = 29;  // root bits, root <= 2^28

  localparam int PROD_LAT = 2;
  localparam int SQRT_LAT = 3 + SQRT_BITS;

  localparam logic signed [TW-1:0] Q_ONE = {{(TW-29){1'b0}}, 1'b1, 28'd0};
  localparam logic signed [TW-1:0] Q_NEG_ONE = -Q_ONE;
  localparam logic signed [AW-1:0] PITCH_POS = 16'sd16384;
  localparam logic signed [AW-1:0] PITCH_NEG = -16'sd16384;

  typedef struct packed {
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [AW-1:0] roll_angle;
    logic signed [AW-1:0] pitch_angle;
    logic signed [AW-1:0] yaw_angle;
    logic                 pitch_clamped;
  } euler_t;

  typedef struct packed {
    logic signed [TW-1:0] sr;
    logic signed [TW-1:0] cr;
    logic signed [TW-1:0] sy;
    logic signed [TW-1:0] cy;
    logic signed [TW-1:0] sp;
  } terms_t;

  typedef struct packed {
    logic hi;
    logic lo;
  } clamp_t;

  // atan(2^-i) with pi = 2^31
  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] r;
    unique case (i)
      0:  r = 34'sh020000000;
      1:  r = 34'sh012E4051D;
      2:  r = 34'sh009FB385B;
      3:  r = 34'sh0051111D4;
      4:  r = 34'sh0028B0D43;
      5:  r = 34'sh00145D7E1;
      6:  r = 34'sh000A2F61E;
      7:  r = 34'sh000517C55;
      8:  r = 34'sh00028BE53;
      9:  r = 34'sh000145F2E;
      10: r = 34'sh0000A2F98;
      11: r = 34'sh0000517CC;
      12: r = 34'sh000028BE6;
      13: r = 34'sh0000145F3;
      14: r = 34'sh00000A2F9;
      15: r = 34'sh00000517C;
      16: r = 34'sh0000028BE;
      17: r = 34'sh00000145F;
      18: r = 34'sh000000A2F;
      19: r = 34'sh000000517;
      20: r = 34'sh00000028B;
      21: r = 34'sh000000145;
      22: r = 34'sh0000000A2;
      23: r = 34'sh000000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/qte_delay.sv
// Enabled shift-register delay line for side data.
module qte_delay
  import qte_pkg::*;
#(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

// File: sv/qte_products.sv
// Quaternion product terms: multiplies, then the five Q28 sums.
module qte_products
  import qte_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  quat_t  quat,
  output terms_t terms
);

  logic signed [PW-1:0] wx, yz, wz, xy, wy, zx, xx, yy, zz;

  always_ff @(posedge clk) begin
    if (en) begin
      wx <= quat.quat_w * quat.quat_x;
      yz <= quat.quat_y * quat.quat_z;
      wz <= quat.quat_w * quat.quat_z;
      xy <= quat.quat_x * quat.quat_y;
      wy <= quat.quat_w * quat.quat_y;
      zx <= quat.quat_z * quat.quat_x;
      xx <= quat.quat_x * quat.quat_x;
      yy <= quat.quat_y * quat.quat_y;
      zz <= quat.quat_z * quat.quat_z;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      terms.sr <= (TW'(wx) + TW'(yz)) <<< 1;
      terms.cr <= Q_ONE - ((TW'(xx) + TW'(yy)) <<< 1);
      terms.sy <= (TW'(wz) + TW'(xy)) <<< 1;
      terms.cy <= Q_ONE - ((TW'(yy) + TW'(zz)) <<< 1);
      terms.sp <= (TW'(wy) - TW'(zx)) <<< 1;
    end
  end

endmodule

// File: sv/qte_isqrt.sv
// Pipelined cos(pitch) = floor(sqrt(2^56 - s^2)), one root bit per stage.
module qte_isqrt
  import qte_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [TW-1:0] sp,
  output logic [SQRT_BITS-1:0] root
);

  logic [MW-1:0]   mag;
  logic [2*MW-1:0] sq;
  logic [RW-1:0]   v_s [SQRT_BITS+1];
  logic [RW-1:0]   r_s [SQRT_BITS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      mag    <= sp[TW-1] ? MW'(-sp) : sp[MW-1:0];
      sq     <= mag * mag;
      v_s[0] <= (RW'(1) << (2*MW)) - RW'(sq);
      r_s[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQRT_BITS; k++) begin : g_stage
    localparam logic [RW-1:0] BIT = RW'(1) << (2*(SQRT_BITS-1-k));
    logic [RW-1:0] trial;
    assign trial = r_s[k] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (v_s[k] >= trial) begin
          v_s[k+1] <= v_s[k] - trial;
          r_s[k+1] <= (r_s[k] >> 1) + BIT;
        end else begin
          v_s[k+1] <= v_s[k];
          r_s[k+1] <= r_s[k] >> 1;
        end
      end
    end
  end

  assign root = r_s[SQRT_BITS][SQRT_BITS-1:0];

endmodule

// File: sv/qte_cordic.sv
// Pipelined vectoring CORDIC atan2, one micro-rotation per stage.
module qte_cordic
  import qte_pkg::*;
#(
  parameter int STEPS = DEF_CORDIC_STEPS
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [TW-1:0] yin,
  input  logic signed [TW-1:0] xin,
  output logic signed [AW-1:0] angle
);

  logic signed [CW-1:0] x_s [STEPS+1];
  logic signed [CW-1:0] y_s [STEPS+1];
  logic signed [ZW-1:0] z_s [STEPS+1];
  logic                 zero_s [STEPS+1];
  logic signed [CW-1:0] xe, ye;
  logic signed [ZW-1:0] zr;

  assign xe = CW'(xin);
  assign ye = CW'(yin);

  // quadrant fold into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      zero_s[0] <= (xin == '0) && (yin == '0);
      if (!xin[TW-1]) begin
        x_s[0] <= xe;
        y_s[0] <= ye;
        z_s[0] <= '0;
      end else if (!yin[TW-1]) begin
        x_s[0] <= ye;
        y_s[0] <= -xe;
        z_s[0] <= atan_entry(0) <<< 1;
      end else begin
        x_s[0] <= -ye;
        y_s[0] <= xe;
        z_s[0] <= -(atan_entry(0) <<< 1);
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ATAN = atan_entry(i);
    logic signed [CW-1:0] xs, ys;
    assign xs = x_s[i] >>> i;
    assign ys = y_s[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        zero_s[i+1] <= zero_s[i];
        if (!y_s[i][CW-1] && (y_s[i] != '0)) begin
          x_s[i+1] <= x_s[i] + ys;
          y_s[i+1] <= y_s[i] - xs;
          z_s[i+1] <= z_s[i] + ATAN;
        end else begin
          x_s[i+1] <= x_s[i] - ys;
          y_s[i+1] <= y_s[i] + xs;
          z_s[i+1] <= z_s[i] - ATAN;
        end
      end
    end
  end

  // round half up to the 16-bit binary angle
  assign zr = z_s[STEPS] + ZW'(32768);

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= zero_s[STEPS] ? '0 : zr[AW+15:16];
    end
  end

endmodule

// File: sv/quaternion_to_euler.sv
// Top level: unit quaternion to ZYX roll, pitch and yaw binary angles.
//
// Takes one Q1.14 quaternion beat per cycle, unless the output is stalled, and
// returns roll, pitch and yaw as 16-bit binary angles (32768 = pi), plus a flag
// when pitch saturates at +/-pi/2. The datapath is a pipeline of product and sum
// registers, the square root of 1 - s^2 (one root bit per stage), three parallel
// CORDIC units and one output register. When the output is stalled the whole
// pipeline holds, and quat_stall follows euler_stall while a result is waiting.
// No reset state other than the valid bits.
module quaternion_to_euler
  import qte_pkg::*;
#(
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   quat_valid,
  output logic   quat_stall,
  input  quat_t  quat,
  output logic   euler_valid,
  input  logic   euler_stall,
  output euler_t euler
);

  localparam int STEPS      = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int CORDIC_LAT = STEPS + 2;
  localparam int TOTAL      = PROD_LAT + SQRT_LAT + CORDIC_LAT + 1;

  logic             en;
  logic [TOTAL-1:0] vld;
  terms_t           terms, terms_d;
  clamp_t           clamp_in, clamp_d;
  logic [SQRT_BITS-1:0] cos_p;
  logic signed [AW-1:0] roll_a, pitch_a, yaw_a;

  // whole pipeline advances unless a finished beat is held at the output
  assign en          = !(euler_valid && euler_stall);
  assign quat_stall  = !en;
  assign euler_valid = vld[TOTAL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL-2:0], quat_valid};
    end
  end

  qte_products u_products (
    .clk   (clk),
    .en    (en),
    .quat  (quat),
    .terms (terms)
  );

  // saturation of sin(pitch)
  assign clamp_in.hi = terms.sp >= Q_ONE;
  assign clamp_in.lo = terms.sp <= Q_NEG_ONE;

  qte_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .sp   (terms.sp),
    .root (cos_p)
  );

  // roll, yaw and sin terms wait for the square root
  qte_delay #(.W($bits(terms_t)), .DEPTH(SQRT_LAT)) u_terms_dly (
    .clk  (clk),
    .en   (en),
    .din  (terms),
    .dout (terms_d)
  );

  qte_delay #(.W($bits(clamp_t)), .DEPTH(SQRT_LAT + CORDIC_LAT)) u_clamp_dly (
    .clk  (clk),
    .en   (en),
    .din  (clamp_in),
    .dout (clamp_d)
  );

  qte_cordic #(.STEPS(STEPS)) u_roll (
    .clk   (clk),
    .en    (en),
    .yin   (terms_d.sr),
    .xin   (terms_d.cr),
    .angle (roll_a)
  );

  qte_cordic #(.STEPS(STEPS)) u_pitch (
    .clk   (clk),
    .en    (en),
    .yin   (terms_d.sp),
    .xin   (TW'(cos_p)),
    .angle (pitch_a)
  );

  qte_cordic #(.STEPS(STEPS)) u_yaw (
    .clk   (clk),
    .en    (en),
    .yin   (terms_d.sy),
    .xin   (terms_d.cy),
    .angle (yaw_a)
  );

  // output register; saturated pitch overrides the CORDIC result
  always_ff @(posedge clk) begin
    if (en) begin
      euler.roll_angle    <= roll_a;
      euler.yaw_angle     <= yaw_a;
      euler.pitch_clamped <= clamp_d.hi || clamp_d.lo;
      if (clamp_d.hi) begin
        euler.pitch_angle <= PITCH_POS;
      end else if (clamp_d.lo) begin
        euler.pitch_angle <= PITCH_NEG;
      end else begin
        euler.pitch_angle <= pitch_a;
      end
    end
  end

endmodule

// File: tb/quaternion_to_euler_test.sv
// Testbench for quaternion_to_euler: directed table plus random beats, checked by a predictor.
module quaternion_to_euler_test;
  import qte_pkg::*;

  localparam int STEPS = DEF_CORDIC_STEPS;
  localparam int LATENCY = STEPS + 37;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_BEATS = 780;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   quat_valid = 1'b0;
  logic   quat_stall;
  quat_t  quat = '0;
  logic   euler_valid;
  logic   euler_stall = 1'b0;
  euler_t euler;

  quaternion_to_euler #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst(rst),
    .quat_valid(quat_valid), .quat_stall(quat_stall), .quat(quat),
    .euler_valid(euler_valid), .euler_stall(euler_stall), .euler(euler)
  );

  always #4 clk = ~clk;

  // Angles in flight, oldest first.
  euler_t pending_angles[$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  bit     stimulus_done = 1'b0;

  // Directed row: a beat and, where obvious, the angles it must give.
  typedef struct {
    quat_t  q;
    bit     known;
    euler_t e;
  } vector_t;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Signed right shift on 64-bit values; >>> on a signed type is arithmetic.
  function automatic longint shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Vectoring CORDIC atan2, binary angle with pi = 2^31 internally.
  function automatic logic [AW-1:0] cordic_angle(input longint yv, input longint xv);
    longint cx = xv;
    longint cy = yv;
    longint acc = 0;
    longint t;
    longint xs;
    longint ys;
    longint step;
    if (cx == 0 && cy == 0) return '0;
    if (cx < 0) begin
      t = cx;
      if (cy >= 0) begin
        cx = cy; cy = -t; acc = 64'sh40000000;
      end else begin
        cx = -cy; cy = t; acc = -64'sh40000000;
      end
    end
    for (int i = 0; i < STEPS && i < ATAN_LEN; i++) begin
      xs = shr(cx, i);
      ys = shr(cy, i);
      step = longint'(atan_entry(i));
      if (cy > 0) begin
        cx = cx + ys; cy = cy - xs; acc += step;
      end else begin
        cx = cx - ys; cy = cy + xs; acc -= step;
      end
    end
    acc = shr(acc + 32768, 16);
    return acc[AW-1:0];
  endfunction

  function automatic euler_t quat_angles(input quat_t q);
    euler_t r;
    longint w = longint'(q.quat_w);
    longint x = longint'(q.quat_x);
    longint y = longint'(q.quat_y);
    longint z = longint'(q.quat_z);
    longint one = 64'sd1 << 28;
    longint s_roll = 2 * (w * x + y * z);
    longint c_roll = one - 2 * (x * x + y * y);
    longint s_yaw = 2 * (w * z + x * y);
    longint c_yaw = one - 2 * (y * y + z * z);
    longint s_pitch = 2 * (w * y - z * x);
    longint c_pitch;
    if (s_pitch >= one) begin
      r.pitch_angle = PITCH_POS;
      r.pitch_clamped = 1'b1;
    end else if (s_pitch <= -one) begin
      r.pitch_angle = PITCH_NEG;
      r.pitch_clamped = 1'b1;
    end else begin
      c_pitch = longint'(int_sqrt((64'd1 << 56) - longint'(s_pitch * s_pitch)));
      r.pitch_angle = cordic_angle(s_pitch, c_pitch);
      r.pitch_clamped = 1'b0;
    end
    r.roll_angle = cordic_angle(s_roll, c_roll);
    r.yaw_angle = cordic_angle(s_yaw, c_yaw);
    return r;
  endfunction

  function automatic quat_t make_quat(input int w, input int x, input int y, input int z);
    quat_t q;
    q.quat_w = w[15:0]; q.quat_x = x[15:0]; q.quat_y = y[15:0]; q.quat_z = z[15:0];
    return q;
  endfunction

  function automatic euler_t make_euler(input int r, input int p, input int yw, input bit c);
    euler_t e;
    e.roll_angle = r[15:0]; e.pitch_angle = p[15:0]; e.yaw_angle = yw[15:0];
    e.pitch_clamped = c;
    return e;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 70);
  endfunction

  function automatic int random_component();
    int kind = $urandom_range(0, 9);
    if (kind == 0) return int'($urandom_range(0, 65535)) - 32768;  // full 16-bit range
    if (kind == 1) return ($urandom_range(0, 1)) ? 16384 : -16384;
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  // Random quaternion: mostly random components scaled to norm 16384, else raw components or near gimbal lock.
  function automatic quat_t random_quat();
    real c[4];
    real n;
    int kind = $urandom_range(0, 9);
    if (kind < 2)
      return make_quat(random_component(), random_component(),
                       random_component(), random_component());
    if (kind == 2) begin
      // near gimbal lock: w == y or w == -y with x, z small
      c[0] = real'($urandom_range(9000, 11600));
      c[2] = ($urandom_range(0, 1)) ? c[0] : -c[0];
      c[1] = real'(int'($urandom_range(0, 400)) - 200);
      c[3] = real'(int'($urandom_range(0, 400)) - 200);
      return make_quat(int'(c[0]), int'(c[1]), int'(c[2]), int'(c[3]));
    end
    for (int i = 0; i < 4; i++) c[i] = real'(int'($urandom_range(0, 20000)) - 10000);
    n = $sqrt(c[0]*c[0] + c[1]*c[1] + c[2]*c[2] + c[3]*c[3]);
    if (n < 1.0) return make_quat(16384, 0, 0, 0);
    for (int i = 0; i < 4; i++) c[i] = c[i] * 16384.0 / n;
    return make_quat($rtoi(c[0]), $rtoi(c[1]), $rtoi(c[2]), $rtoi(c[3]));
  endfunction

  // Valid stays high across back-to-back beats; it drops only for a gap or a drain.
  task automatic send_beat(input quat_t q, input euler_t want);
    int gap = gap_len();
    if (gap != 0) begin
      quat_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    quat <= q;
    quat_valid <= 1'b1;
    pending_angles.push_back(want);
    @(posedge clk);
    while (quat_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    quat_valid <= 1'b0;
    @(negedge clk);
    while (pending_angles.size() != 0) @(negedge clk);
  endtask

  // Stimulus.
  initial begin
    vector_t table_rows[$];
    vector_t v;
    quat_t   q;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // identity, zero, extremes, clamp cases (expected typed in where obvious)
    table_rows.push_back('{make_quat(16384, 0, 0, 0), 1, make_euler(0, 0, 0, 0)});
    table_rows.push_back('{make_quat(0, 0, 0, 0), 1, make_euler(0, 0, 0, 0)});
    table_rows.push_back('{make_quat(-16384, 0, 0, 0), 1, make_euler(0, 0, 0, 0)});
    // pitch +pi/2: w = y = 1/sqrt2 rounded up so s >= 1
    table_rows.push_back('{make_quat(11586, 0, 11586, 0), 0, '0});
    table_rows.push_back('{make_quat(11586, 0, -11586, 0), 0, '0});
    table_rows.push_back('{make_quat(0, 0, 16384, 0), 0, '0});  // roll and yaw of pi
    table_rows.push_back('{make_quat(0, 16384, 0, 0), 0, '0});
    table_rows.push_back('{make_quat(0, 0, 0, 16384), 0, '0});
    table_rows.push_back('{make_quat(32767, 32767, 32767, 32767), 0, '0});
    table_rows.push_back('{make_quat(-32768, -32768, -32768, -32768), 0, '0});
    table_rows.push_back('{make_quat(32767, -32768, 32767, -32768), 0, '0});
    table_rows.push_back('{make_quat(-32768, 32767, 0, 1), 0, '0});
    table_rows.push_back('{make_quat(16384, 16384, 16384, 16384), 0, '0});
    table_rows.push_back('{make_quat(11585, 11585, 0, 0), 0, '0});
    table_rows.push_back('{make_quat(11585, 0, 0, -11585), 0, '0});
    table_rows.push_back('{make_quat(11585, 0, 11585, 0), 0, '0});  // just under the clamp
    table_rows.push_back('{make_quat(1, -1, 1, -1), 0, '0});
    table_rows.push_back('{make_quat(-1, 16384, -16384, 5), 0, '0});
    table_rows.push_back('{make_quat(21845, -21846, 10922, -10923), 0, '0});

    foreach (table_rows[i]) begin
      v = table_rows[i];
      send_beat(v.q, v.known ? v.e : quat_angles(v.q));
    end

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      // one hold-off until the pipeline is empty, halfway through
      if (n == RANDOM_BEATS / 2) drain();
      q = random_quat();
      send_beat(q, quat_angles(q));
    end
    quat_valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Result side stall: random gaps, with one long stretch of no stalls.
  initial begin
    int hold;
    euler_stall <= 1'b0;
    @(negedge clk);
    while (1) begin
      hold = ($realtime > 4000 && $realtime < 8000) ? 0 : gap_len();
      if (hold != 0) begin
        euler_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      euler_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  // Result checker and watchdog; sampled at the rising edge.
  always @(posedge clk) begin
    euler_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((quat_valid && !quat_stall) || (euler_valid && !euler_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (euler_valid && !euler_stall) begin
        if (pending_angles.size() == 0) begin
          report_mismatch("unexpected beat", 0, 0);
        end else begin
          want = pending_angles.pop_front();
          if (euler.roll_angle !== want.roll_angle)
            report_mismatch("roll_angle", euler.roll_angle, want.roll_angle);
          if (euler.pitch_angle !== want.pitch_angle)
            report_mismatch("pitch_angle", euler.pitch_angle, want.pitch_angle);
          if (euler.yaw_angle !== want.yaw_angle)
            report_mismatch("yaw_angle", euler.yaw_angle, want.yaw_angle);
          if (euler.pitch_clamped !== want.pitch_clamped)
            report_mismatch("pitch_clamped", euler.pitch_clamped, want.pitch_clamped);
        end
      end
    end
  end

  // End of run: drain, let the pipeline settle, then verdict.
  initial begin
    wait (!rst);
    while (!(stimulus_done && pending_angles.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("quaternion_to_euler regression: fail");
      $finish;
    end else begin
      repeat (2 * LATENCY) @(posedge clk);
      if (mismatches == 0 && pending_angles.size() == 0) begin
        $display("quaternion_to_euler regression: pass");
      end else begin
        $display("quaternion_to_euler regression: fail");
      end
      $finish;
    end
  end

endmodule

// File: filelist.f
sv/qte_pkg.sv
sv/qte_delay.sv
sv/qte_products.sv
sv/qte_isqrt.sv
sv/qte_cordic.sv
sv/quaternion_to_euler.sv
tb/quaternion_to_euler_test.sv
